[rtl/luv_pkg.sv]
// Package for the LAN UDP frame validator: widths, constants, register and error codes.
`timescale 1ns / 1ps
package luv_pkg;

    localparam int COUNT_W = 17;
    localparam int SIZE_W  = COUNT_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] ETH_HDR_BYTES  = 17'd14;
    localparam logic [SIZE_W-1:0]  MIN_FRAME_BYTES = 18'd34;
    localparam logic [SIZE_W-1:0]  UDP_HDR_BYTES  = 18'd8;
    localparam logic [15:0]        IPV4_ETHERTYPE = 16'h0800;
    localparam logic [7:0]         UDP_PROTOCOL   = 8'h11;
    localparam logic [3:0]         IPV4_VERSION   = 4'd4;
    localparam logic [3:0]         IHL_MASK       = 4'b1111;

    localparam logic [15:0] EXPECTED_PORT_RST = 16'd3074;
    localparam logic [31:0] UNICAST_IP_RST    = 32'h0000_0001;
    localparam logic [31:0] BROADCAST_IP_RST  = 32'hFFFF_FFFF;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_EXPECTED_PORT = 2'd0,
        REG_UNICAST_IP    = 2'd1,
        REG_BROADCAST_IP  = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ERR_OK         = 4'd0,
        ERR_SHORT      = 4'd1,
        ERR_NOT_IPV4   = 4'd2,
        ERR_NOT_UDP    = 4'd3,
        ERR_IP_LEN     = 4'd4,
        ERR_UDP_SHORT  = 4'd5,
        ERR_SPORT      = 4'd6,
        ERR_DPORT      = 4'd7,
        ERR_SIP        = 4'd8,
        ERR_SMAC_BCAST = 4'd9,
        ERR_BCAST_DIP  = 4'd10,
        ERR_DIP        = 4'd11,
        ERR_UDP_LEN    = 4'd12
    } err_code_t;

endpackage

[rtl/lan_udp_frame_validator.sv]
// LAN UDP frame validator: Ethernet/IPv4/UDP header capture and per-frame verdict.
// The verdict for a last word is computed from the input register into the result register
// and shown on m_tvalid.
// Throughput: one byte word per cycle unless a last word is held back; one verdict word per frame. A last word
// waits in the input register while an unaccepted verdict holds the result register.
// Reset: aresetn is synchronous, active low; clears the frame state and valid flags
// and returns the configuration registers to their defaults.
`timescale 1ns / 1ps
module lan_udp_frame_validator (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: [7:0] data_byte
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tlast,   // last_byte
    // m_tdata: [0] frame_ok, [4:1] error_code, [7:5] zero
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [luv_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import luv_pkg::*;

    // configuration
    logic [15:0] expected_port_reg;
    logic [31:0] unicast_ip_reg;
    logic [31:0] broadcast_ip_reg;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_port_reg <= EXPECTED_PORT_RST;
            unicast_ip_reg    <= UNICAST_IP_RST;
            broadcast_ip_reg  <= BROADCAST_IP_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                REG_EXPECTED_PORT: expected_port_reg <= pwdata[15:0];
                REG_UNICAST_IP:    unicast_ip_reg    <= pwdata;
                REG_BROADCAST_IP:  broadcast_ip_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_EXPECTED_PORT: prdata = {16'd0, expected_port_reg};
            REG_UNICAST_IP:    prdata = unicast_ip_reg;
            REG_BROADCAST_IP:  prdata = broadcast_ip_reg;
            default:           prdata = 32'd0;
        endcase
    end

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       out_free;
    logic       consume;

    // result register
    logic       m_valid_reg;
    logic [7:0] m_data_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // frame state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0] ether_type_reg, ether_type_next, cap_ether_type;
    logic [7:0]  version_ihl_reg, version_ihl_next, cap_version_ihl;
    logic [7:0]  ip_protocol_reg, ip_protocol_next, cap_ip_protocol;
    logic [15:0] ip_total_length_reg, ip_total_length_next, cap_ip_total_length;
    logic [31:0] source_ip_reg, source_ip_next, cap_source_ip;
    logic [31:0] dest_ip_reg, dest_ip_next, cap_dest_ip;
    logic        dest_mac_ones_reg, dest_mac_ones_next, cap_dest_mac_ones;
    logic        source_mac_ones_reg, source_mac_ones_next, cap_source_mac_ones;
    logic [15:0] udp_sport_reg, udp_sport_next, cap_udp_sport;
    logic [15:0] udp_dport_reg, udp_dport_next, cap_udp_dport;
    logic [15:0] udp_length_reg, udp_length_next, cap_udp_length;

    logic [COUNT_W-1:0] p;
    logic [7:0]         b;
    logic [7:0]         vihl;
    logic [COUNT_W-1:0] uoff_cap;
    logic [COUNT_W-1:0] udp_pos;
    logic [SIZE_W-1:0]  size;
    logic [SIZE_W-1:0]  uoff_v;
    err_code_t          code;

    assign p = byte_count_reg;
    assign b = in_data_reg;

    // capture of the current byte
    always_comb begin
        cap_ether_type      = ether_type_reg;
        cap_version_ihl     = version_ihl_reg;
        cap_ip_protocol     = ip_protocol_reg;
        cap_ip_total_length = ip_total_length_reg;
        cap_source_ip       = source_ip_reg;
        cap_dest_ip         = dest_ip_reg;
        cap_dest_mac_ones   = dest_mac_ones_reg;
        cap_source_mac_ones = source_mac_ones_reg;
        cap_udp_sport       = udp_sport_reg;
        cap_udp_dport       = udp_dport_reg;
        cap_udp_length      = udp_length_reg;

        if (p < 17'd6) begin
            cap_dest_mac_ones = dest_mac_ones_reg && (b == 8'hFF);
        end else if (p < 17'd12) begin
            cap_source_mac_ones = source_mac_ones_reg && (b == 8'hFF);
        end else if (p < ETH_HDR_BYTES) begin
            cap_ether_type = {ether_type_reg[7:0], b};
        end else if (p == ETH_HDR_BYTES) begin
            cap_version_ihl = b;
        end else if (p == 17'd16 || p == 17'd17) begin
            cap_ip_total_length = {ip_total_length_reg[7:0], b};
        end else if (p == 17'd23) begin
            cap_ip_protocol = b;
        end else if (p >= 17'd26 && p < 17'd30) begin
            cap_source_ip = {source_ip_reg[23:0], b};
        end else if (p >= 17'd30 && p < 17'd34) begin
            cap_dest_ip = {dest_ip_reg[23:0], b};
        end

        vihl     = (p == ETH_HDR_BYTES) ? b : version_ihl_reg;
        uoff_cap = ETH_HDR_BYTES + {11'd0, vihl[3:0] & IHL_MASK, 2'b00};
        udp_pos  = p - uoff_cap;
        if (p >= ETH_HDR_BYTES && p >= uoff_cap) begin
            if (udp_pos < 17'd2) begin
                cap_udp_sport = {udp_sport_reg[7:0], b};
            end else if (udp_pos < 17'd4) begin
                cap_udp_dport = {udp_dport_reg[7:0], b};
            end else if (udp_pos < 17'd6) begin
                cap_udp_length = {udp_length_reg[7:0], b};
            end
        end
    end

    // verdict, first failing check wins
    always_comb begin
        size   = {1'b0, p} + 18'd1;
        uoff_v = 18'd14 + {12'd0, cap_version_ihl[3:0] & IHL_MASK, 2'b00};
        if (size < MIN_FRAME_BYTES) begin
            code = ERR_SHORT;
        end else if (cap_version_ihl[7:4] != IPV4_VERSION
                     || cap_ether_type != IPV4_ETHERTYPE) begin
            code = ERR_NOT_IPV4;
        end else if (cap_ip_protocol != UDP_PROTOCOL) begin
            code = ERR_NOT_UDP;
        end else if ({2'b00, cap_ip_total_length} + 18'd14 != size) begin
            code = ERR_IP_LEN;
        end else if (uoff_v + UDP_HDR_BYTES > size) begin
            code = ERR_UDP_SHORT;
        end else if (cap_udp_sport != expected_port_reg) begin
            code = ERR_SPORT;
        end else if (cap_udp_dport != expected_port_reg) begin
            code = ERR_DPORT;
        end else if (cap_source_ip != unicast_ip_reg) begin
            code = ERR_SIP;
        end else if (cap_source_mac_ones) begin
            code = ERR_SMAC_BCAST;
        end else if (cap_dest_mac_ones && cap_dest_ip != broadcast_ip_reg) begin
            code = ERR_BCAST_DIP;
        end else if (!cap_dest_mac_ones && cap_dest_ip != unicast_ip_reg) begin
            code = ERR_DIP;
        end else if ({2'b00, cap_udp_length} + uoff_v != size) begin
            code = ERR_UDP_LEN;
        end else begin
            code = ERR_OK;
        end
    end

    // next frame state: clear after the last word, saturating count otherwise
    always_comb begin
        if (in_last_reg) begin
            byte_count_next      = '0;
            ether_type_next      = '0;
            version_ihl_next     = '0;
            ip_protocol_next     = '0;
            ip_total_length_next = '0;
            source_ip_next       = '0;
            dest_ip_next         = '0;
            dest_mac_ones_next   = 1'b1;
            source_mac_ones_next = 1'b1;
            udp_sport_next       = '0;
            udp_dport_next       = '0;
            udp_length_next      = '0;
        end else begin
            byte_count_next      = (p < COUNT_MAX) ? p + 17'd1 : p;
            ether_type_next      = cap_ether_type;
            version_ihl_next     = cap_version_ihl;
            ip_protocol_next     = cap_ip_protocol;
            ip_total_length_next = cap_ip_total_length;
            source_ip_next       = cap_source_ip;
            dest_ip_next         = cap_dest_ip;
            dest_mac_ones_next   = cap_dest_mac_ones;
            source_mac_ones_next = cap_source_mac_ones;
            udp_sport_next       = cap_udp_sport;
            udp_dport_next       = cap_udp_dport;
            udp_length_next      = cap_udp_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg      <= '0;
            ether_type_reg      <= '0;
            version_ihl_reg     <= '0;
            ip_protocol_reg     <= '0;
            ip_total_length_reg <= '0;
            source_ip_reg       <= '0;
            dest_ip_reg         <= '0;
            dest_mac_ones_reg   <= 1'b1;
            source_mac_ones_reg <= 1'b1;
            udp_sport_reg       <= '0;
            udp_dport_reg       <= '0;
            udp_length_reg      <= '0;
        end else if (consume) begin
            byte_count_reg      <= byte_count_next;
            ether_type_reg      <= ether_type_next;
            version_ihl_reg     <= version_ihl_next;
            ip_protocol_reg     <= ip_protocol_next;
            ip_total_length_reg <= ip_total_length_next;
            source_ip_reg       <= source_ip_next;
            dest_ip_reg         <= dest_ip_next;
            dest_mac_ones_reg   <= dest_mac_ones_next;
            source_mac_ones_reg <= source_mac_ones_next;
            udp_sport_reg       <= udp_sport_next;
            udp_dport_reg       <= udp_dport_next;
            udp_length_reg      <= udp_length_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (consume && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_last_reg) begin
            m_data_reg <= {3'b000, code, (code == ERR_OK)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[tb/sv/tb_lan_udp_frame_validator.sv]
// Self-checking testbench for lan_udp_frame_validator: directed and random frames.
`timescale 1ns / 1ps
module tb_lan_udp_frame_validator;
    import luv_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 50;
    localparam int REG_UNUSED     = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_word_t;

    typedef struct packed {
        logic      ok;
        err_code_t code;
    } verdict_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    lan_udp_frame_validator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),    // [7:0] data_byte
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),    // [0] frame_ok, [4:1] error_code, [7:5] zero
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 aclk = ~aclk;

    // configuration as last written
    logic [15:0] cfg_port  = EXPECTED_PORT_RST;
    logic [31:0] cfg_ucast = UNICAST_IP_RST;
    logic [31:0] cfg_bcast = BROADCAST_IP_RST;

    // header capture state of the predictor
    logic [COUNT_W-1:0] hdr_count;
    logic [15:0]        hdr_ethertype;
    logic [7:0]         hdr_vihl;
    logic [7:0]         hdr_proto;
    logic [15:0]        hdr_total_len;
    logic [31:0]        hdr_sip;
    logic [31:0]        hdr_dip;
    logic               hdr_dmac_bcast;
    logic               hdr_smac_bcast;
    logic [15:0]        hdr_sport;
    logic [15:0]        hdr_dport;
    logic [15:0]        hdr_udp_len;

    byte_word_t byte_q[$];
    verdict_t   verdict_q[$];
    logic [7:0] frm[$];

    bit rx_hold_req  = 1'b0;
    int err_count    = 0;
    int idle_cycles  = 0;

    function automatic void clear_header();
        hdr_count      = '0;
        hdr_ethertype  = '0;
        hdr_vihl       = '0;
        hdr_proto      = '0;
        hdr_total_len  = '0;
        hdr_sip        = '0;
        hdr_dip        = '0;
        hdr_dmac_bcast = 1'b1;
        hdr_smac_bcast = 1'b1;
        hdr_sport      = '0;
        hdr_dport      = '0;
        hdr_udp_len    = '0;
    endfunction

    function automatic int unsigned udp_start(logic [7:0] vihl);
        return 32'(ETH_HDR_BYTES) + 4 * 32'(vihl[3:0] & IHL_MASK);
    endfunction

    function automatic void capture_byte(int unsigned pos, logic [7:0] b);
        int unsigned uoff;
        if (pos < 6) hdr_dmac_bcast &= (b == 8'hFF);
        else if (pos < 12) hdr_smac_bcast &= (b == 8'hFF);
        else if (pos < 14) hdr_ethertype = {hdr_ethertype[7:0], b};
        else if (pos == 14) hdr_vihl = b;
        else if (pos == 16 || pos == 17) hdr_total_len = {hdr_total_len[7:0], b};
        else if (pos == 23) hdr_proto = b;
        else if (pos >= 26 && pos < 30) hdr_sip = {hdr_sip[23:0], b};
        else if (pos >= 30 && pos < 34) hdr_dip = {hdr_dip[23:0], b};
        if (pos < 32'(ETH_HDR_BYTES)) return;
        // UDP offset follows IHL even when it lands inside the IP header
        uoff = udp_start(hdr_vihl);
        if (pos < uoff) return;
        if (pos - uoff < 2) hdr_sport = {hdr_sport[7:0], b};
        else if (pos - uoff < 4) hdr_dport = {hdr_dport[7:0], b};
        else if (pos - uoff < 6) hdr_udp_len = {hdr_udp_len[7:0], b};
    endfunction

    function automatic err_code_t frame_verdict(int unsigned size);
        int unsigned uoff;
        uoff = udp_start(hdr_vihl);
        if (size < 32'(MIN_FRAME_BYTES)) return ERR_SHORT;
        if (hdr_vihl[7:4] != IPV4_VERSION || hdr_ethertype != IPV4_ETHERTYPE)
            return ERR_NOT_IPV4;
        if (hdr_proto != UDP_PROTOCOL) return ERR_NOT_UDP;
        if (32'(hdr_total_len) + 32'(ETH_HDR_BYTES) != size) return ERR_IP_LEN;
        if (uoff + 32'(UDP_HDR_BYTES) > size) return ERR_UDP_SHORT;
        if (hdr_sport != cfg_port) return ERR_SPORT;
        if (hdr_dport != cfg_port) return ERR_DPORT;
        if (hdr_sip != cfg_ucast) return ERR_SIP;
        if (hdr_smac_bcast) return ERR_SMAC_BCAST;
        if (hdr_dmac_bcast) begin
            if (hdr_dip != cfg_bcast) return ERR_BCAST_DIP;
        end else if (hdr_dip != cfg_ucast) begin
            return ERR_DIP;
        end
        if (32'(hdr_udp_len) + uoff != size) return ERR_UDP_LEN;
        return ERR_OK;
    endfunction

    // returns 1 when the word closes a frame and a verdict is due
    function automatic logic predict_word(logic [7:0] b, logic last, output verdict_t v);
        int unsigned pos;
        pos = hdr_count;
        v = '0;
        capture_byte(pos, b);
        if (!last) begin
            if (hdr_count != COUNT_MAX) hdr_count++;
            return 1'b0;
        end
        v.code = frame_verdict(pos + 1);
        v.ok   = (v.code == ERR_OK);
        clear_header();
        return 1'b1;
    endfunction

    task automatic report_error(string field, int got, int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // sender
    int tx_gap   = 0;
    bit tx_burst = 1'b0;
    always @(posedge aclk) begin
        byte_word_t w;
        logic       nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            nv = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (byte_q.size() > 0) begin
                w = byte_q.pop_front();
                s_tdata <= w.data;
                s_tlast <= w.last;
                nv = 1'b1;
                if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 12);
            end
            s_tvalid <= nv;
        end
    end

    // receiver, predictor and checker
    int rx_stall     = 0;
    int rx_hold      = 0;
    bit rx_burst     = 1'b0;
    bit rx_hold_done = 1'b0;
    always @(posedge aclk) begin
        verdict_t exp_v;
        logic     nr;
        if (!aresetn) begin
            clear_header();
            verdict_q.delete();
            m_tready <= 1'b0;
            rx_stall = 0;
            rx_hold  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (predict_word(s_tdata, s_tlast, exp_v)) verdict_q.push_back(exp_v);
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_error("unexpected verdict word", int'(m_tdata), 0);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_tdata[0] !== exp_v.ok)
                        report_error("frame_ok", int'(m_tdata[0]), int'(exp_v.ok));
                    if (m_tdata[4:1] !== exp_v.code)
                        report_error("error_code", int'(m_tdata[4:1]), int'(exp_v.code));
                    if (m_tdata[7:5] !== 3'b000)
                        report_error("tdata padding", int'(m_tdata[7:5]), 0);
                end
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 12);
            end
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold      = LONG_HOLD;
                rx_hold_done = 1'b1;
            end
            nr = (rx_hold == 0 && rx_stall == 0);
            if (rx_hold > 0) rx_hold--;
            else if (rx_stall > 0) rx_stall--;
            m_tready <= nr;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic apb_write(int idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EXPECTED_PORT: cfg_port  = value[15:0];
            REG_UNICAST_IP:    cfg_ucast = value;
            REG_BROADCAST_IP:  cfg_bcast = value;
            default: ;
        endcase
    endtask

    task automatic write_config(logic [15:0] port, logic [31:0] ucast, logic [31:0] bcast);
        apb_write(REG_EXPECTED_PORT, {16'h0, port});
        apb_write(REG_UNICAST_IP, ucast);
        apb_write(REG_BROADCAST_IP, bcast);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (byte_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic void put16(int at, logic [15:0] v);
        frm[at]     = v[15:8];
        frm[at + 1] = v[7:0];
    endfunction

    function automatic void put32(int at, logic [31:0] v);
        put16(at, v[31:16]);
        put16(at + 2, v[15:0]);
    endfunction

    function automatic void trim(int n);
        while (frm.size() > n) void'(frm.pop_back());
    endfunction

    function automatic void fill_frame(int n, logic [7:0] value);
        frm.delete();
        repeat (n) frm.push_back(value);
    endfunction

    // well-formed frame for the current configuration when IHL is 5 or more
    function automatic void make_frame(int ihl, int pay_len, bit dbcast);
        int uoff;
        int size;
        uoff = 14 + 4 * ihl;
        size = uoff + 8 + pay_len;
        if (size < 34) size = 34;
        frm.delete();
        repeat (size) frm.push_back(8'($urandom));
        for (int i = 0; i < 6; i++) if (dbcast) frm[i] = 8'hFF;
        if (!dbcast) frm[$urandom_range(0, 5)] = 8'($urandom_range(0, 254));
        frm[6 + $urandom_range(0, 5)] = 8'($urandom_range(0, 254));
        put16(12, IPV4_ETHERTYPE);
        frm[14] = {IPV4_VERSION, 4'(ihl)};
        put16(16, 16'(size - 14));
        frm[23] = UDP_PROTOCOL;
        put32(26, cfg_ucast);
        put32(30, dbcast ? cfg_bcast : cfg_ucast);
        put16(uoff, cfg_port);
        put16(uoff + 2, cfg_port);
        put16(uoff + 4, 16'(size - uoff));
    endfunction

    // break one check of a well-formed frame with IHL of 5 or more
    function automatic void mutate(err_code_t kind);
        int uoff;
        int n;
        uoff = 14 + 4 * frm[14][3:0];
        case (kind)
            ERR_SHORT: trim($urandom_range(1, 33));
            ERR_NOT_IPV4: begin
                if ($urandom_range(0, 1))
                    put16(12, IPV4_ETHERTYPE ^ 16'($urandom_range(1, 65535)));
                else
                    frm[14] = {IPV4_VERSION ^ 4'($urandom_range(1, 15)), frm[14][3:0]};
            end
            ERR_NOT_UDP: frm[23] = UDP_PROTOCOL ^ 8'($urandom_range(1, 255));
            ERR_IP_LEN: put16(16, 16'(frm.size() - 14) ^ 16'($urandom_range(1, 65535)));
            ERR_UDP_SHORT: begin
                n = $urandom_range(34, uoff + 7);
                trim(n);
                put16(16, 16'(n - 14));
            end
            ERR_SPORT: put16(uoff, cfg_port ^ 16'($urandom_range(1, 65535)));
            ERR_DPORT: put16(uoff + 2, cfg_port ^ 16'($urandom_range(1, 65535)));
            ERR_SIP: put32(26, cfg_ucast ^ ($urandom() | 32'h1));
            ERR_SMAC_BCAST: for (int i = 6; i < 12; i++) frm[i] = 8'hFF;
            ERR_BCAST_DIP: begin
                for (int i = 0; i < 6; i++) frm[i] = 8'hFF;
                put32(30, cfg_bcast ^ ($urandom() | 32'h1));
            end
            ERR_DIP: begin
                frm[0] = 8'($urandom_range(0, 254));
                put32(30, cfg_ucast ^ ($urandom() | 32'h1));
            end
            ERR_UDP_LEN: put16(uoff + 4, 16'(frm.size() - uoff) ^ 16'($urandom_range(1, 65535)));
            default: ;
        endcase
    endfunction

    function automatic void push_frame();
        foreach (frm[i]) byte_q.push_back('{data: frm[i], last: (i == frm.size() - 1)});
    endfunction

    // random bytes with stray last flags, closed by a last word
    function automatic void push_noise(int n);
        for (int i = 0; i < n; i++)
            byte_q.push_back('{data: 8'($urandom),
                               last: (i == n - 1) || ($urandom_range(0, 15) == 0)});
    endfunction

    task automatic run_random(int min_bytes, int min_frames);
        int bytes;
        int frames;
        int r;
        int ihl;
        bytes  = 0;
        frames = 0;
        @(negedge aclk);
        while (bytes < min_bytes || frames < min_frames) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                frm.delete();
                r = $urandom_range(1, 60);
                push_noise(r);
                bytes += r;
            end else begin
                ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7);
                make_frame(ihl, $urandom_range(0, 24), 1'($urandom_range(0, 1)));
                if (r >= 45 && ihl >= 5) mutate(err_code_t'($urandom_range(1, 12)));
                push_frame();
                bytes += frm.size();
            end
            frames++;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames at reset configuration
        make_frame(5, 0, 1'b0);
        push_frame();
        make_frame(5, 12, 1'b1);
        push_frame();
        make_frame(5, 3, 1'b0);
        trim(1);
        push_frame();
        make_frame(5, 3, 1'b0);
        trim(33);
        push_frame();
        make_frame(3, 0, 1'b0);
        push_frame();
        for (int k = ERR_NOT_IPV4; k <= ERR_UDP_LEN; k++) begin
            make_frame(5, $urandom_range(0, 8), k == ERR_BCAST_DIP);
            mutate(err_code_t'(k));
            push_frame();
        end
        make_frame(0, 4, 1'b0);
        push_frame();
        make_frame(4, 2, 1'b1);
        push_frame();
        make_frame(15, 3, 1'b1);
        push_frame();
        fill_frame(40, 8'hFF);
        push_frame();
        fill_frame(40, 8'h00);
        push_frame();
        wait_idle();

        apb_write(REG_UNUSED, $urandom());
        @(negedge aclk);
        run_random(120, 3);
        wait_idle();

        write_config(16'h0000, 32'h0000_0000, 32'h0000_0000);
        run_random(180, 4);
        wait_idle();

        write_config(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(180, 4);
        wait_idle();

        // receiver stalls for a long stretch while short frames keep coming
        write_config(16'($urandom), $urandom(), $urandom());
        rx_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) push_noise($urandom_range(1, 3));
        run_random(100, 2);
        wait_idle();

        write_config(16'($urandom), $urandom(), $urandom());
        run_random(180, 4);
        wait_idle();

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
